/* hdl/assert_macros.svh */
// Assertion macros shared by the boot slot selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define BSS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* hdl/bss_pkg.sv */
// Types and codes shared by the boot slot selector modules.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SELECT = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_CHK_PREF = 3'd1,
		ST_CHK_CUR  = 3'd2,
		ST_SCAN     = 3'd3,
		ST_FINISH   = 3'd4,
		ST_WRITE    = 3'd5
	} state_t;

	localparam logic [2:0] RSN_PREFERRED   = 3'd0;
	localparam logic [2:0] RSN_CURRENT     = 3'd1;
	localparam logic [2:0] RSN_SCAN_GOOD   = 3'd2;
	localparam logic [2:0] RSN_SCAN_VALID  = 3'd3;
	localparam logic [2:0] RSN_ROUND_ROBIN = 3'd4;

endpackage

`default_nettype wire

/* hdl/bss_eval.sv */
// Shared count unit: increment and good-boot compare.
`timescale 1ns / 1ps
`default_nettype none

module bss_eval #(
	parameter int WIDTH = 32
) (
	input  wire logic [WIDTH-1:0] base,
	input  wire logic [WIDTH-1:0] probe,
	output logic      [WIDTH-1:0] sum,
	output logic                  good
);

	// Wrap at the counter width.
	assign sum  = base + 1'b1;
	assign good = (probe == base) || (probe == sum);

endmodule

`default_nettype wire

/* hdl/boot_slot_selector_core.sv */
// Boot slot selector top level: slot table, selection sequencer and ports.
// Write and load beats leave the sequencer idle, so the block is ready again the next cycle.
// A select beat reads one slot record per cycle through the count memory port, in order:
//   preferred slot, then current slot, then a scan from the current slot, then a fallback.
// One item is in flight at a time; a finished result waits in the output register.
// Reset (arst_n low, asynchronous) clears flags, preferred and current slot and global count; counts read as zero.
`timescale 1ns / 1ps
`default_nettype none

module boot_slot_selector_core #(
	parameter int NUM_SLOTS  = 4,
	parameter int COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [1:0]  slot_index,
	input  wire logic        image_complete,
	input  wire logic        checksum_ok,
	input  wire logic [31:0] boot_count,
	input  wire logic [31:0] last_success_count,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       selected_slot,
	output logic [2:0]       selection_reason,
	output logic [31:0]      new_global_count,
	output logic [31:0]      new_slot_count
);

`include "assert_macros.svh"

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CB     = COUNT_BITS;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		slot_next = (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Architectural state
	// ---------------------------------------------------------------
	bss_pkg::state_t   state_q, state_d;
	logic [1:0]        preferred_q;
	logic [SLOT_W-1:0] cur_q;
	logic [CB-1:0]     glob_q;
	logic [NUM_SLOTS-1:0] cpl_q;
	logic [NUM_SLOTS-1:0] ok_q;
	// Entries not yet written read as zero counts.
	logic [NUM_SLOTS-1:0] written_q;
	logic [2*CB-1:0]   cnt_mem_q [NUM_SLOTS];

	// Count memory port
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] rd_addr_q;
	logic [2*CB-1:0]   rd_word_q;
	logic              rd_written_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [2*CB-1:0]   mem_wdata;
	logic [CB-1:0]     rd_bc;
	logic [CB-1:0]     rd_ls;

	// Sequencer working registers
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] step_q;
	logic              fv_q;
	logic [SLOT_W-1:0] fv_slot_q;
	logic [CB-1:0]     fv_bc_q;
	logic [CB-1:0]     fv_ls_q;
	logic [SLOT_W-1:0] sel_q;
	logic [2:0]        reason_q;
	logic [CB-1:0]     sel_bc_q;
	logic [CB-1:0]     sel_ls_q;

	// Output register
	logic              out_valid_q;
	logic [1:0]        out_slot_q;
	logic [2:0]        out_reason_q;
	logic [31:0]       out_glob_q;
	logic [31:0]       out_cnt_q;

	// Decision from the sequencer
	logic              dec_take;
	logic [SLOT_W-1:0] dec_slot;
	logic [2:0]        dec_reason;
	logic [CB-1:0]     dec_bc;
	logic [CB-1:0]     dec_ls;
	logic              fv_capture;
	logic              result_fire;

	// Shared unit
	logic [CB-1:0]     eval_base;
	logic [CB-1:0]     eval_sum;
	logic              eval_good;

	logic              in_fire;
	logic              op_write;
	logic              op_select;
	logic              op_load;
	logic              idx_in_range;
	logic              pref_in_range;
	logic [SLOT_W-1:0] ld_slot;
	logic              cand_valid;
	logic              cand_vg;
	logic              scan_last;
	logic [CB-1:0]     glob_inc;

	assign in_ready  = (state_q == bss_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign op_write  = (operation == bss_pkg::OP_WRITE);
	assign op_select = (operation == bss_pkg::OP_SELECT);
	assign op_load   = (operation == bss_pkg::OP_LOAD);

	assign idx_in_range  = (int'(slot_index) < NUM_SLOTS);
	assign pref_in_range = (int'(preferred_q) < NUM_SLOTS);
	// With two or more slots a two-bit index is below twice the slot count, so one subtract wraps it.
	assign ld_slot = idx_in_range ? SLOT_W'(slot_index)
	                              : SLOT_W'(int'(slot_index) - NUM_SLOTS);

	assign rd_bc = rd_written_q ? rd_word_q[CB-1:0]    : '0;
	assign rd_ls = rd_written_q ? rd_word_q[2*CB-1:CB] : '0;

	// Valid flags are plain flops; the candidate is the slot read last cycle.
	assign cand_valid = cpl_q[rd_addr_q] && ok_q[rd_addr_q];
	assign cand_vg    = cand_valid && eval_good;
	assign scan_last  = (step_q == SLOT_W'(NUM_SLOTS - 1));
	assign glob_inc   = glob_q + 1'b1;

	// The unit tests the read record while probing and bumps the chosen count at the end.
	assign eval_base = (state_q == bss_pkg::ST_WRITE) ? sel_bc_q : rd_ls;

	bss_eval #(
		.WIDTH (CB)
	) u_eval (
		.base  (eval_base),
		.probe (rd_bc),
		.sum   (eval_sum),
		.good  (eval_good)
	);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		dec_take    = 1'b0;
		dec_slot    = rd_addr_q;
		dec_reason  = bss_pkg::RSN_PREFERRED;
		dec_bc      = rd_bc;
		dec_ls      = rd_ls;
		fv_capture  = 1'b0;
		result_fire = 1'b0;
		rd_addr     = cur_q;
		case (state_q)
			bss_pkg::ST_IDLE: begin
				// Issue the preferred slot read as the select beat lands.
				rd_addr = SLOT_W'(preferred_q);
				if (in_fire && op_select) begin
					state_d = bss_pkg::ST_CHK_PREF;
				end
			end
			bss_pkg::ST_CHK_PREF: begin
				rd_addr = cur_q;
				if (pref_in_range && cand_vg) begin
					dec_take   = 1'b1;
					dec_reason = bss_pkg::RSN_PREFERRED;
					state_d    = bss_pkg::ST_WRITE;
				end else begin
					state_d = bss_pkg::ST_CHK_CUR;
				end
			end
			bss_pkg::ST_CHK_CUR: begin
				// The scan starts at the current slot, so read it again.
				rd_addr = cur_q;
				if (cand_vg) begin
					dec_take   = 1'b1;
					dec_reason = bss_pkg::RSN_CURRENT;
					state_d    = bss_pkg::ST_WRITE;
				end else begin
					state_d = bss_pkg::ST_SCAN;
				end
			end
			bss_pkg::ST_SCAN: begin
				// On the last step fetch current+1 for the round-robin fallback.
				rd_addr = scan_last ? slot_next(cur_q) : slot_next(ptr_q);
				if (cand_vg) begin
					dec_take   = 1'b1;
					dec_reason = bss_pkg::RSN_SCAN_GOOD;
					state_d    = bss_pkg::ST_WRITE;
				end else begin
					fv_capture = cand_valid && !fv_q;
					if (scan_last) begin
						state_d = bss_pkg::ST_FINISH;
					end
				end
			end
			bss_pkg::ST_FINISH: begin
				dec_take = 1'b1;
				if (fv_q) begin
					dec_slot   = fv_slot_q;
					dec_bc     = fv_bc_q;
					dec_ls     = fv_ls_q;
					dec_reason = bss_pkg::RSN_SCAN_VALID;
				end else begin
					dec_reason = bss_pkg::RSN_ROUND_ROBIN;
				end
				state_d = bss_pkg::ST_WRITE;
			end
			bss_pkg::ST_WRITE: begin
				// Hold until the output register can take the result.
				if (!out_valid_q || out_ready) begin
					result_fire = 1'b1;
					state_d     = bss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bss_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Count memory: one write port, one registered read port
	// ---------------------------------------------------------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sel_q;
		mem_wdata = {sel_ls_q, eval_sum};
		if (result_fire) begin
			mem_we = 1'b1;
		end else if (in_fire && op_write && idx_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = SLOT_W'(slot_index);
			mem_wdata = {CB'(last_success_count), CB'(boot_count)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_word_q <= cnt_mem_q[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// ---------------------------------------------------------------
	// Slot flags, current slot, global count, configuration
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preferred_q  <= '0;
			cur_q        <= '0;
			glob_q       <= '0;
			cpl_q        <= '0;
			ok_q         <= '0;
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			rd_written_q <= written_q[rd_addr];
			if (cfg_wr_en) begin
				preferred_q <= cfg_wr_data;
			end
			if (mem_we) begin
				written_q[mem_waddr] <= 1'b1;
			end
			if (in_fire && op_write && idx_in_range) begin
				cpl_q[SLOT_W'(slot_index)] <= image_complete;
				ok_q[SLOT_W'(slot_index)]  <= checksum_ok;
			end
			if (in_fire && op_load) begin
				cur_q  <= ld_slot;
				glob_q <= CB'(boot_count);
			end
			if (result_fire) begin
				cur_q  <= sel_q;
				glob_q <= glob_inc;
			end
		end
	end

	// ---------------------------------------------------------------
	// Scan bookkeeping and chosen slot
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q   <= 1'b0;
			ptr_q  <= '0;
			step_q <= '0;
		end else begin
			if (in_fire && op_select) begin
				fv_q   <= 1'b0;
				ptr_q  <= cur_q;
				step_q <= '0;
			end else if (state_q == bss_pkg::ST_SCAN) begin
				ptr_q  <= slot_next(ptr_q);
				step_q <= step_q + 1'b1;
				if (fv_capture) begin
					fv_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fv_capture) begin
			fv_slot_q <= rd_addr_q;
			fv_bc_q   <= rd_bc;
			fv_ls_q   <= rd_ls;
		end
		if (dec_take) begin
			sel_q    <= dec_slot;
			reason_q <= dec_reason;
			sel_bc_q <= dec_bc;
			sel_ls_q <= dec_ls;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_fire) begin
			out_slot_q   <= 2'(sel_q);
			out_reason_q <= reason_q;
			out_glob_q   <= 32'(glob_inc);
			out_cnt_q    <= 32'(eval_sum);
		end
	end

	assign out_valid        = out_valid_q;
	assign selected_slot    = out_slot_q;
	assign selection_reason = out_reason_q;
	assign new_global_count = out_glob_q;
	assign new_slot_count   = out_cnt_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`BSS_ASSERT(a_result_from_write, $rose(out_valid_q) |-> $past(state_q == bss_pkg::ST_WRITE), "result beat without a finished select")
	`BSS_ASSERT(a_current_follows, $rose(out_valid_q) |-> (cur_q == sel_q), "current slot not updated to the chosen slot")
	`BSS_ASSERT(a_pref_reason, (out_valid_q && out_reason_q == bss_pkg::RSN_PREFERRED) |-> (out_slot_q == preferred_q), "preferred reason with another slot")
	`BSS_ASSERT_NEVER(a_sel_range, state_q == bss_pkg::ST_WRITE && int'(sel_q) >= NUM_SLOTS, "chosen slot out of range")

endmodule

`default_nettype wire
